/* rtl/core/aae_pkg.sv */
// types and constants shared by the adaptive arithmetic encoder
// no dependencies
package aae_pkg;

   localparam int CW = 24;  // cumulative count width
   localparam int RW = 31;  // code register width
   localparam int PW = 32;  // pending count width
   localparam int SYMW = 8;
   localparam int ALW = 9;
   localparam int GRP = 16; // cells per select group

   localparam logic [RW-1:0] TOP_VAL  = 31'h7FFF_FFFF;
   localparam logic [RW-1:0] QTR1_VAL = 31'h2000_0000;
   localparam logic [RW-1:0] QTR3_VAL = 31'h6000_0000;

   localparam logic CMD_ENCODE = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_CLAMP,
      ST_DIV,
      ST_MUL,
      ST_HIGH,
      ST_LOW,
      ST_HALF,
      ST_QUART,
      ST_UPDATE,
      ST_FLUSH
   } enc_state_type;

   typedef struct packed {
      logic init;
      logic bump;
   } cell_ctl_type;

endpackage

/* rtl/core/aae_cell.sv */
// one cell of the cumulative count chain
// depends on aae_pkg
module aae_cell import aae_pkg::*; #(
   parameter int SW  = 9,
   parameter int IDX = 0
) (
   input  logic          clock,
   input  cell_ctl_type  ctl,
   input  logic [SW-1:0] sym,
   input  logic          prev_hit,
   output logic          hit,
   output logic [CW-1:0] sel_lo,
   output logic [CW-1:0] sel_hi
);

   logic [CW-1:0] cum_ff;
   logic [CW-1:0] cum_in;
   logic          above;

   assign hit    = (sym == SW'(IDX));
   assign above  = (32'(sym) < 32'(IDX));
   // the left neighbour's hit means this cell holds the upper bound
   assign sel_lo = hit ? cum_ff : '0;
   assign sel_hi = prev_hit ? cum_ff : '0;

   always_comb begin
      cum_in = cum_ff;
      if (ctl.init) begin
         cum_in = CW'(IDX);
      end else if (ctl.bump && above) begin
         cum_in = cum_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      cum_ff <= cum_in;
   end

endmodule

/* rtl/core/aae_div.sv */
// restoring divider, one quotient bit a cycle
// depends on aae_pkg
module aae_div import aae_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [31:0]   num,
   input  logic [CW-1:0] den,
   output logic          done,
   output logic [RW-1:0] quot
);

   logic [CW:0]   rem_ff, rem_in;
   logic [31:0]   q_ff, q_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic [CW:0]   trial;
   logic          ge;

   assign trial = {rem_ff[CW-1:0], q_ff[31]};
   assign ge    = (trial >= {1'b0, den});
   assign done  = run_ff && (cnt_ff == 5'd31);
   assign quot  = q_ff[RW-1:0];

   always_comb begin
      rem_in = rem_ff;
      q_in   = q_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      if (start) begin
         rem_in = '0;
         q_in   = num;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? (trial - {1'b0, den}) : trial;
         q_in   = {q_ff[30:0], ge};
         cnt_in = cnt_ff + 5'd1;
         if (done) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

endmodule

/* rtl/core/adaptive_arithmetic_encoder.sv */
// adaptive arithmetic encoder: one symbol per word, 31-bit code registers
// a symbol steps through prep, clamp, divide, multiply, high and low bounds, half
// shifts, quarter expansions and the model update; finish sends one closing word
// one word at a time; words wait while the output register is full and stalled
// reset clears the coder registers; the count chain is built at the first symbol after reset or a finish
// depends on aae_pkg, aae_cell, aae_div
module adaptive_arithmetic_encoder import aae_pkg::*; #(
   parameter int MAX_SYMBOLS = 256,
   parameter int MAX_TOTAL   = 16777215
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic            req_cmd,
   input  logic [SYMW-1:0] req_symbol,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic            rsp_lead_bit,
   output logic [PW-1:0]   rsp_follow_count,
   output logic            rsp_last,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [ALW-1:0]  csr_alphabet_size
);

   localparam int SW = $clog2(MAX_SYMBOLS + 1);
   localparam int NC = MAX_SYMBOLS + 1;
   localparam int NG = (NC + GRP - 1) / GRP;
   localparam int MW = RW + CW;

   enc_state_type   state_ff, state_in;
   logic [ALW-1:0]  alpha_ff, alpha_in;
   logic [SW-1:0]   size_ff, size_in;
   logic            ready_ff, ready_in;
   logic [CW-1:0]   total_ff, total_in;
   logic [RW-1:0]   low_ff, low_in, high_ff, high_in;
   logic [PW-1:0]   pend_ff, pend_in;
   logic [SYMW-1:0] raw_ff, raw_in;
   logic [SW-1:0]   sym_ff, sym_in;
   logic [MW-1:0]   p0_ff, p0_in, p1_ff, p1_in;
   logic [5:0]      nres_ff, nres_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_lead_ff, rsp_lead_in;
   logic [PW-1:0]   rsp_follow_ff, rsp_follow_in;
   logic            rsp_last_ff, rsp_last_in;
   logic [CW-1:0]   grp0_ff [NG];
   logic [CW-1:0]   grp1_ff [NG];
   logic [CW-1:0]   grp0_in [NG];
   logic [CW-1:0]   grp1_in [NG];
   logic [CW-1:0]   c0_ff, c0_in, c1_ff, c1_in;

   cell_ctl_type    ctl;
   logic [NC:0]     hit;
   logic [CW-1:0]   sel0 [NC];
   logic [CW-1:0]   sel1 [NC];
   logic            div_start, div_done;
   logic [RW-1:0]   step;
   logic [31:0]     div_num;
   logic [SW-1:0]   eff_size;
   logic            out_free;
   logic [MW:0]     sum_hi, sum_lo;
   logic            half_c, half_n, quart_c;
   logic [RW-1:0]   lo_s, hi_s, lo_q, hi_q;
   logic [PW-1:0]   pend_inc;
   logic            bump_ok;

   assign csr_ready        = 1'b1;
   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_lead_bit     = rsp_lead_ff;
   assign rsp_follow_count = rsp_follow_ff;
   assign rsp_last         = rsp_last_ff;
   assign out_free         = !rsp_valid_ff || !rsp_stall;

   // cumulative count chain
   assign hit[0] = 1'b0;
   for (genvar i = 0; i < NC; i++) begin : g_cell
      aae_cell #(.SW(SW), .IDX(i)) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .sym      (sym_ff),
         .prev_hit (hit[i]),
         .hit      (hit[i+1]),
         .sel_lo   (sel0[i]),
         .sel_hi   (sel1[i])
      );
   end

   aae_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (total_ff),
      .done  (div_done),
      .quot  (step)
   );

   // two-level registered select of the bounds for the current symbol
   always_comb begin
      for (int g = 0; g < NG; g++) begin
         grp0_in[g] = '0;
         grp1_in[g] = '0;
         for (int k = 0; k < GRP; k++) begin
            if (g * GRP + k < NC) begin
               grp0_in[g] = grp0_in[g] | sel0[g * GRP + k];
               grp1_in[g] = grp1_in[g] | sel1[g * GRP + k];
            end
         end
      end
      c0_in = '0;
      c1_in = '0;
      for (int g = 0; g < NG; g++) begin
         c0_in = c0_in | grp0_ff[g];
         c1_in = c1_in | grp1_ff[g];
      end
   end

   always_comb begin
      if (32'(alpha_ff) < 32'd2) begin
         eff_size = SW'(2);
      end else if (32'(alpha_ff) > 32'(MAX_SYMBOLS)) begin
         eff_size = SW'(MAX_SYMBOLS);
      end else begin
         eff_size = SW'(alpha_ff);
      end
   end

   assign div_num  = 32'(high_ff) - 32'(low_ff) + 32'd1 + 32'(total_ff) - 32'd1;
   assign sum_hi   = (MW+1)'(low_ff) + (MW+1)'(p1_ff) - (MW+1)'(1);
   assign sum_lo   = (MW+1)'(low_ff) + (MW+1)'(p0_ff);
   assign half_c   = !high_ff[RW-1] || low_ff[RW-1];
   assign lo_s     = {low_ff[RW-2:0], 1'b0};
   assign hi_s     = {high_ff[RW-2:0], 1'b1};
   assign half_n   = !hi_s[RW-1] || lo_s[RW-1];
   assign quart_c  = (low_ff >= QTR1_VAL) && (high_ff < QTR3_VAL);
   assign lo_q     = {RW'(low_ff - QTR1_VAL)} << 1;
   assign hi_q     = {RW'(high_ff - QTR1_VAL)} << 1 | RW'(1);
   assign pend_inc = (pend_ff == '1) ? pend_ff : pend_ff + PW'(1);
   assign bump_ok  = (total_ff < CW'(MAX_TOTAL));

   always_comb begin
      state_in      = state_ff;
      alpha_in      = alpha_ff;
      size_in       = size_ff;
      ready_in      = ready_ff;
      total_in      = total_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      pend_in       = pend_ff;
      raw_in        = raw_ff;
      sym_in        = sym_ff;
      p0_in         = p0_ff;
      p1_in         = p1_ff;
      nres_in       = nres_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_lead_in   = rsp_lead_ff;
      rsp_follow_in = rsp_follow_ff;
      rsp_last_in   = rsp_last_ff;
      ctl           = '0;
      div_start     = 1'b0;

      if (csr_valid && csr_ready) begin
         alpha_in = csr_alphabet_size;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               raw_in   = req_symbol;
               state_in = (req_cmd == CMD_FINISH) ? ST_FLUSH : ST_PREP;
            end
         end
         ST_PREP: begin
            if (!ready_ff) begin
               ctl.init = 1'b1;
               size_in  = eff_size;
               total_in = CW'(eff_size);
               ready_in = 1'b1;
            end
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            if (32'(raw_ff) >= 32'(size_ff)) begin
               sym_in = size_ff - SW'(1);
            end else begin
               sym_in = SW'(raw_ff);
            end
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            p0_in    = MW'(step) * MW'(c0_ff);
            p1_in    = MW'(step) * MW'(c1_ff);
            state_in = ST_HIGH;
         end
         ST_HIGH: begin
            if (sum_hi <= (MW+1)'(high_ff)) begin
               high_in = sum_hi[RW-1:0];
            end
            state_in = ST_LOW;
         end
         ST_LOW: begin
            if (sum_lo > (MW+1)'(high_ff)) begin
               low_in = high_ff;
            end else begin
               low_in = sum_lo[RW-1:0];
            end
            nres_in  = '0;
            state_in = ST_HALF;
         end
         ST_HALF: begin
            if (!half_c) begin
               state_in = ST_QUART;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_lead_in   = high_ff[RW-1];
               rsp_follow_in = pend_ff;
               rsp_last_in   = !half_n || (nres_ff == 6'd31);
               pend_in       = '0;
               low_in        = lo_s;
               high_in       = hi_s;
               nres_in       = nres_ff + 6'd1;
               if (rsp_last_in) begin
                  state_in = ST_QUART;
               end
            end
         end
         ST_QUART: begin
            if (quart_c) begin
               pend_in = pend_inc;
               low_in  = lo_q;
               high_in = hi_q;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (bump_ok) begin
               ctl.bump = 1'b1;
               total_in = total_ff + CW'(1);
            end
            state_in = ST_IDLE;
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_lead_in   = (low_ff >= QTR1_VAL);
               rsp_follow_in = pend_inc;
               rsp_last_in   = 1'b1;
               low_in        = '0;
               high_in       = TOP_VAL;
               pend_in       = '0;
               ready_in      = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         alpha_ff     <= ALW'(256);
         ready_ff     <= 1'b0;
         low_ff       <= '0;
         high_ff      <= TOP_VAL;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         nres_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         alpha_ff     <= alpha_in;
         ready_ff     <= ready_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         nres_ff      <= nres_in;
      end
      size_ff       <= size_in;
      total_ff      <= total_in;
      raw_ff        <= raw_in;
      sym_ff        <= sym_in;
      p0_ff         <= p0_in;
      p1_ff         <= p1_in;
      rsp_lead_ff   <= rsp_lead_in;
      rsp_follow_ff <= rsp_follow_in;
      rsp_last_ff   <= rsp_last_in;
      grp0_ff       <= grp0_in;
      grp1_ff       <= grp1_in;
      c0_ff         <= c0_in;
      c1_ff         <= c1_in;
   end

   // the code interval never inverts
   a_interval: assert property (@(posedge clock) disable iff (reset)
      low_ff <= high_ff) else $error("code interval inverted");

   // a flush with a free output register delivers a closing word
   a_flush: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && out_free) |=> (rsp_valid && rsp_last))
      else $error("flush word missing");

   // the model total stays within its limit once built
   a_total: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> (32'(total_ff) <= 32'(MAX_TOTAL)))
      else $error("count total over limit");

   // the divider finishes before the multiply step
   a_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> $past(div_done))
      else $error("multiply without quotient");

endmodule

/* tb/aae_code_checker.sv */
`timescale 1ns / 100ps
// checker for the adaptive arithmetic encoder: follows the coder and its count model
// from the accepted words and compares every output run; depends on aae_pkg
module aae_code_checker import aae_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_stall,
   input  logic            req_cmd,
   input  logic [SYMW-1:0] req_symbol,
   input  logic            rsp_valid,
   input  logic            rsp_stall,
   input  logic            rsp_lead_bit,
   input  logic [PW-1:0]   rsp_follow_count,
   input  logic            rsp_last,
   input  logic            csr_valid,
   input  logic            csr_ready,
   input  logic [ALW-1:0]  csr_alphabet_size,
   output int              errors,
   output int              runs_due
);

   localparam int MAX_SYMBOLS = 256;
   localparam int MAX_TOTAL   = 16777215;
   localparam logic [RW-1:0] HALF_VAL = 31'h4000_0000;

   typedef struct {
      logic          lead_bit;
      logic [PW-1:0] follow_count;
      logic          last;
   } code_run_type;

   code_run_type  expected_runs[$];
   logic [ALW-1:0] alphabet_reg;
   logic [RW-1:0] code_low, code_high;
   logic [PW-1:0] follow_pending;
   logic [CW-1:0] cum_count[0:MAX_SYMBOLS];
   logic [CW-1:0] count_sum;
   int            model_symbols;
   bit            model_built;
   int            shown;

   assign runs_due = expected_runs.size();

   function automatic logic [PW-1:0] sat_inc(logic [PW-1:0] v);
      return (v == '1) ? v : v + 1;
   endfunction

   task automatic clear_coder();
      code_low = '0;
      code_high = TOP_VAL;
      follow_pending = '0;
      model_built = 0;
   endtask

   task automatic code_word(logic cmd, logic [SYMW-1:0] symbol_in);
      logic [63:0] span, stride, hi, lo;
      int        sym, n;
      code_run_type r;
      n = 0;
      if (cmd != CMD_ENCODE) begin
         follow_pending = sat_inc(follow_pending);
         r.lead_bit = (code_low < QTR1_VAL) ? 1'b0 : 1'b1;
         r.follow_count = follow_pending;
         r.last = 1'b1;
         expected_runs.push_back(r);
         clear_coder();
         return;
      end
      if (!model_built) begin
         model_symbols = alphabet_reg < 2 ? 2 :
                         (alphabet_reg > MAX_SYMBOLS ? MAX_SYMBOLS : int'(alphabet_reg));
         for (int i = 0; i <= model_symbols; i++) cum_count[i] = CW'(i);
         count_sum = CW'(model_symbols);
         model_built = 1;
      end
      sym = symbol_in;
      if (sym >= model_symbols) sym = model_symbols - 1;
      span = 64'(code_high) - 64'(code_low) + 1;
      stride = (span + 64'(count_sum) - 1) / 64'(count_sum);
      hi = 64'(code_low) + stride * 64'(cum_count[sym+1]) - 1;
      if (hi > 64'(code_high)) hi = 64'(code_high);
      lo = 64'(code_low) + stride * 64'(cum_count[sym]);
      if (lo > hi) lo = hi;
      code_high = hi[RW-1:0];
      code_low = lo[RW-1:0];
      while ((code_high < HALF_VAL || code_low >= HALF_VAL) && n < 32) begin
         if (code_high < HALF_VAL) begin
            r.lead_bit = 1'b0;
            code_low = code_low << 1;
            code_high = (code_high << 1) | 1'b1;
         end else begin
            r.lead_bit = 1'b1;
            code_low = (code_low - HALF_VAL) << 1;
            code_high = ((code_high - HALF_VAL) << 1) | 1'b1;
         end
         r.follow_count = follow_pending;
         r.last = 1'b0;
         expected_runs.push_back(r);
         follow_pending = '0;
         n++;
      end
      if (n > 0) expected_runs[expected_runs.size()-1].last = 1'b1;
      while (code_low >= QTR1_VAL && code_high < QTR3_VAL) begin
         follow_pending = sat_inc(follow_pending);
         code_low = (code_low - QTR1_VAL) << 1;
         code_high = ((code_high - QTR1_VAL) << 1) | 1'b1;
      end
      if (count_sum < MAX_TOTAL) begin
         for (int i = sym + 1; i <= model_symbols; i++) cum_count[i] = cum_count[i] + 1'b1;
         count_sum = count_sum + 1'b1;
      end
   endtask

   always @(posedge clock) begin
      code_run_type e;
      if (reset) begin
         alphabet_reg = 9'd256;
         clear_coder();
         expected_runs.delete();
         errors = 0;
         shown = 0;
      end else begin
         if (csr_valid && csr_ready) alphabet_reg = csr_alphabet_size;
         if (req_valid && !req_stall) code_word(req_cmd, req_symbol);
         if (rsp_valid && !rsp_stall) begin
            if (expected_runs.size() == 0) begin
               errors++;
               if (shown < 10) begin
                  shown++;
                  $display("unexpected word: lead %0d follow %0d last %0d",
                           rsp_lead_bit, rsp_follow_count, rsp_last);
               end
            end else begin
               e = expected_runs.pop_front();
               if (e.lead_bit !== rsp_lead_bit || e.follow_count !== rsp_follow_count ||
                   e.last !== rsp_last) begin
                  errors++;
                  if (shown < 10) begin
                     shown++;
                     $display("mismatch: expected lead %0d follow %0d last %0d, got %0d %0d %0d",
                              e.lead_bit, e.follow_count, e.last,
                              rsp_lead_bit, rsp_follow_count, rsp_last);
                  end
               end
            end
         end
      end
   end

endmodule

/* tb/adaptive_arithmetic_encoder_tb.sv */
`timescale 1ns / 100ps
// top of the encoder testbench: clock, reset, stimulus and verdict
// depends on aae_pkg, adaptive_arithmetic_encoder and aae_code_checker
module adaptive_arithmetic_encoder_tb import aae_pkg::*;;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 150;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   logic            req_cmd = 1'b0;
   logic [SYMW-1:0] req_symbol = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   logic            rsp_lead_bit;
   logic [PW-1:0]   rsp_follow_count;
   logic            rsp_last;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [ALW-1:0]  csr_alphabet_size = '0;

   int errors, runs_due;
   int send_idle_pct = 26, recv_idle_pct = 71;
   int words_sent = 0;
   int hold_left = 0;
   bit held = 0;
   int quiet_cycles = 0;
   int cur_symbols = 256;

   adaptive_arithmetic_encoder uut (.*);

   aae_code_checker checker_i (.*);

   initial forever #5 clock = ~clock;

   // receiver: random stall, plus one long hold-off in the last phase
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!held && words_sent >= 200) begin
         rsp_stall <= 1'b1;
         hold_left <= 300;
         held <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("adaptive_arithmetic_encoder_tb failed");
         $finish;
      end
   end

   task automatic send_word(bit cmd, logic [SYMW-1:0] sym);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_symbol <= sym;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   // stop offering, let every run arrive and the block go quiet
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (runs_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_alphabet(logic [ALW-1:0] n);
      csr_valid <= 1'b1;
      csr_alphabet_size <= n;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_symbols = n < 2 ? 2 : (n > 256 ? 256 : int'(n));
   endtask

   task automatic random_words(int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 5) send_word(CMD_FINISH, SYMW'($urandom));
         else if (r < 15) send_word(CMD_ENCODE, SYMW'($urandom));
         else if (r < 55)
            send_word(CMD_ENCODE, SYMW'($urandom_range(cur_symbols < 4 ? cur_symbols - 1 : 3)));
         else send_word(CMD_ENCODE, SYMW'($urandom_range(cur_symbols - 1)));
      end
      send_word(CMD_FINISH, '0);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // finish straight after reset, then the symbol extremes at full size
      send_word(CMD_FINISH, '0);
      send_word(CMD_ENCODE, 8'd0);
      send_word(CMD_ENCODE, 8'd255);
      send_word(CMD_ENCODE, 8'd128);
      send_word(CMD_FINISH, 8'hFF);
      drain();
      write_alphabet(9'd511);
      send_word(CMD_ENCODE, 8'd255);
      send_word(CMD_ENCODE, 8'd0);
      send_word(CMD_FINISH, '0);
      drain();
      write_alphabet(9'd0);
      send_word(CMD_ENCODE, 8'd0);
      send_word(CMD_ENCODE, 8'd1);
      send_word(CMD_ENCODE, 8'd255);
      send_word(CMD_ENCODE, 8'd200);
      send_word(CMD_FINISH, '0);
      drain();
      write_alphabet(9'd1);
      send_word(CMD_ENCODE, 8'd1);
      send_word(CMD_ENCODE, 8'd0);
      drain();
      // new size written with a message open only counts from the next one
      write_alphabet(9'd300);
      send_word(CMD_ENCODE, 8'd3);
      send_word(CMD_FINISH, '0);
      send_word(CMD_ENCODE, 8'd3);
      send_word(CMD_ENCODE, 8'd170);
      send_word(CMD_FINISH, '0);
      drain();

      write_alphabet(9'd2);
      random_words(85);
      drain();
      send_idle_pct = 71;
      recv_idle_pct = 26;
      write_alphabet(9'd256);
      random_words(85);
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_alphabet(9'($urandom_range(3, 255)));
      random_words(85);
      drain();

      if (errors == 0)
         $display("adaptive_arithmetic_encoder_tb passed");
      else
         $display("adaptive_arithmetic_encoder_tb failed");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/aae_pkg.sv
rtl/core/aae_cell.sv
rtl/core/aae_div.sv
rtl/core/adaptive_arithmetic_encoder.sv
tb/aae_code_checker.sv
tb/adaptive_arithmetic_encoder_tb.sv
